@@ rtl/cbiq_pkg.sv @@
// Shared types and constants for the cascaded biquad filter unit.
`default_nettype none

package cbiq_pkg;

    localparam int COEFS_PER_SECTION = 6;
    localparam int ACC_BITS          = 64;

    // Command codes of an input word.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Coefficient slots within one section.
    localparam logic [2:0] COEF_A0 = 3'd0;
    localparam logic [2:0] COEF_A1 = 3'd1;
    localparam logic [2:0] COEF_A2 = 3'd2;
    localparam logic [2:0] COEF_B0 = 3'd3;
    localparam logic [2:0] COEF_B1 = 3'd4;
    localparam logic [2:0] COEF_B2 = 3'd5;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_FETCH  = 15'b000000000000010,
        ST_MUL_B0 = 15'b000000000000100,
        ST_MUL_B1 = 15'b000000000001000,
        ST_MUL_B2 = 15'b000000000010000,
        ST_ACC_B2 = 15'b000000000100000,
        ST_RND_C  = 15'b000000001000000,
        ST_CLIP_C = 15'b000000010000000,
        ST_MUL_A0 = 15'b000000100000000,
        ST_MUL_A1 = 15'b000001000000000,
        ST_MUL_A2 = 15'b000010000000000,
        ST_ACC_A2 = 15'b000100000000000,
        ST_RND_Y  = 15'b001000000000000,
        ST_CLIP_Y = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/cascaded_biquad_iir_filter_unit.sv @@
// Cascaded Direct Form 1 biquad filter with one shared multiplier and accumulator.
`default_nettype none

// A load word (command 0) writes one Q2.30 coefficient into the coefficient
// memory in the cycle it is accepted and gives no result. A sample word runs
// through sections 0 to section_count-1 one after another; each section takes
// 13 steps on the single 32x32 multiplier and 64-bit saturating accumulator
// (one fetch, six products, two closing accumulates, two rounding adds and two
// clips), and the result then waits until the output register is free. The
// input is not ready while a sample is in progress; a finished result sits in
// the output register while the next word is accepted.
// Center values and section outputs are rounded half up and saturated, and any
// clip or accumulator saturation within a sample raises the saturated flag.
module cascaded_biquad_iir_filter_unit
    import cbiq_pkg::*;
#(
    parameter int MAX_SECTIONS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_wr_en,
    input  wire logic [3:0]                    cfg_wr_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [2:0]                    s_section_index,
    input  wire logic [2:0]                    s_coef_index,
    input  wire logic signed [31:0]            s_coef_value,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_filtered_sample,
    output logic                               m_saturated
);

    localparam int CENTER_BITS = (SAMPLE_BITS + 4 > 32) ? 32 : SAMPLE_BITS + 4;
    localparam int COEF_DEPTH  = COEFS_PER_SECTION * MAX_SECTIONS;
    localparam int COEF_AW     = $clog2(COEF_DEPTH);
    localparam int SEC_AW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    localparam logic signed [ACC_BITS:0] HALF_LSB =
        (ACC_BITS + 1)'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] C_HI =
        (ACC_BITS'(1) <<< (CENTER_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] C_LO = -C_HI - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] Y_HI =
        (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] Y_LO = -Y_HI - ACC_BITS'(1);

    // Storage: coefficients and the four history lines, each with valid bits
    // so that entries never written read as zero.
    logic signed [31:0]            coef_mem [COEF_DEPTH];
    logic                          coef_vld_reg [COEF_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hx1_mem [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] hx2_mem [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] hy1_mem [MAX_SECTIONS];
    logic signed [SAMPLE_BITS-1:0] hy2_mem [MAX_SECTIONS];
    logic                          hist_vld_reg [MAX_SECTIONS];

    logic signed [31:0]            coef_rd_reg;
    logic                          coef_rd_vld_reg;
    logic signed [SAMPLE_BITS-1:0] hx1_rd_reg, hx2_rd_reg, hy1_rd_reg, hy2_rd_reg;
    logic                          hist_rd_vld_reg;

    state_t                        state_reg, state_next;
    logic [3:0]                    section_count_reg;
    logic [SEC_AW-1:0]             sec_reg, last_sec_reg, last_sec_next;
    logic [COEF_AW-1:0]            base_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [CENTER_BITS-1:0] center_reg;
    logic signed [ACC_BITS-1:0]    prod_reg, acc_reg;
    logic                          flag_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic                          m_sat_reg;

    logic                          in_fire, load_fire, sample_fire, load_ok;
    logic [COEF_AW-1:0]            load_addr, coef_rd_addr;
    logic [2:0]                    coef_off;
    logic signed [31:0]            coef_eff, mul_b;
    logic signed [ACC_BITS-1:0]    prod_full;
    logic signed [SAMPLE_BITS-1:0] x1_eff, x2_eff, y1_eff, y2_eff;
    logic signed [ACC_BITS:0]      add_a, add_b, add_sum;
    logic                          add_ovf;
    logic signed [ACC_BITS-1:0]    add_res, acc_shr;
    logic signed [ACC_BITS-1:0]    clip_c, clip_y;
    logic                          clip_c_hit, clip_y_hit;
    logic                          out_free;
    int                            n_int;

    assign s_ready     = (state_reg == ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign load_fire   = in_fire && (s_command == CMD_LOAD);
    assign sample_fire = in_fire && (s_command == CMD_SAMPLE);
    assign load_ok     = (int'(s_section_index) < MAX_SECTIONS)
                      && (int'(s_coef_index) < COEFS_PER_SECTION);
    assign load_addr   = COEF_AW'(int'(s_section_index) * COEFS_PER_SECTION
                                  + int'(s_coef_index));

    // Sections in use: zero counts as one, and the count is capped.
    always_comb begin
        n_int = int'(section_count_reg);
        if (n_int == 0) begin
            n_int = 1;
        end
        if (n_int > MAX_SECTIONS) begin
            n_int = MAX_SECTIONS;
        end
        last_sec_next = SEC_AW'(n_int - 1);
    end

    // The coefficient read is issued in the state before the multiply that uses it.
    always_comb begin
        case (state_reg)
            ST_FETCH:  coef_off = COEF_B0;
            ST_MUL_B0: coef_off = COEF_B1;
            ST_MUL_B1: coef_off = COEF_B2;
            ST_CLIP_C: coef_off = COEF_A0;
            ST_MUL_A0: coef_off = COEF_A1;
            ST_MUL_A1: coef_off = COEF_A2;
            default:   coef_off = COEF_A0;
        endcase
    end
    assign coef_rd_addr = base_reg + COEF_AW'(coef_off);

    always_ff @(posedge aclk) begin
        if (load_fire && load_ok) begin
            coef_mem[load_addr] <= s_coef_value;
        end
        coef_rd_reg <= coef_mem[coef_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            hx1_rd_reg <= hx1_mem[sec_reg];
            hx2_rd_reg <= hx2_mem[sec_reg];
            hy1_rd_reg <= hy1_mem[sec_reg];
            hy2_rd_reg <= hy2_mem[sec_reg];
        end
        if (state_reg == ST_CLIP_Y) begin
            hx1_mem[sec_reg] <= x_reg;
            hx2_mem[sec_reg] <= x1_eff;
            hy1_mem[sec_reg] <= SAMPLE_BITS'(clip_y);
            hy2_mem[sec_reg] <= y1_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEF_DEPTH; i++) begin
                coef_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                hist_vld_reg[i] <= 1'b0;
            end
            coef_rd_vld_reg <= 1'b0;
            hist_rd_vld_reg <= 1'b0;
        end else begin
            if (load_fire && load_ok) begin
                coef_vld_reg[load_addr] <= 1'b1;
            end
            if (state_reg == ST_CLIP_Y) begin
                hist_vld_reg[sec_reg] <= 1'b1;
            end
            coef_rd_vld_reg <= coef_vld_reg[coef_rd_addr];
            if (state_reg == ST_FETCH) begin
                hist_rd_vld_reg <= hist_vld_reg[sec_reg];
            end
        end
    end

    assign coef_eff = coef_rd_vld_reg ? coef_rd_reg : '0;
    assign x1_eff   = hist_rd_vld_reg ? hx1_rd_reg : '0;
    assign x2_eff   = hist_rd_vld_reg ? hx2_rd_reg : '0;
    assign y1_eff   = hist_rd_vld_reg ? hy1_rd_reg : '0;
    assign y2_eff   = hist_rd_vld_reg ? hy2_rd_reg : '0;

    // Shared multiplier: second operand picked by the step.
    always_comb begin
        case (state_reg)
            ST_MUL_B0: mul_b = 32'(x_reg);
            ST_MUL_B1: mul_b = 32'(x1_eff);
            ST_MUL_B2: mul_b = 32'(x2_eff);
            ST_MUL_A0: mul_b = 32'(center_reg);
            ST_MUL_A1: mul_b = 32'(y1_eff);
            ST_MUL_A2: mul_b = 32'(y2_eff);
            default:   mul_b = '0;
        endcase
    end
    assign prod_full = ACC_BITS'(coef_eff) * ACC_BITS'(mul_b);

    // Shared saturating accumulator; the feedback products are subtracted.
    always_comb begin
        add_a = {acc_reg[ACC_BITS-1], acc_reg};
        case (state_reg)
            ST_MUL_B1, ST_MUL_B2, ST_ACC_B2, ST_MUL_A1:
                add_b = {prod_reg[ACC_BITS-1], prod_reg};
            ST_MUL_A2, ST_ACC_A2:
                add_b = -{prod_reg[ACC_BITS-1], prod_reg};
            ST_RND_C, ST_RND_Y:
                add_b = HALF_LSB;
            default:
                add_b = '0;
        endcase
        add_sum = add_a + add_b;
        add_ovf = add_sum[ACC_BITS] ^ add_sum[ACC_BITS-1];
        if (add_ovf) begin
            add_res = add_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            add_res = add_sum[ACC_BITS-1:0];
        end
    end

    always_comb begin
        acc_shr    = acc_reg >>> COEF_FRAC_BITS;
        clip_c_hit = (acc_shr > C_HI) || (acc_shr < C_LO);
        clip_y_hit = (acc_shr > Y_HI) || (acc_shr < Y_LO);
        if (acc_shr > C_HI) begin
            clip_c = C_HI;
        end else if (acc_shr < C_LO) begin
            clip_c = C_LO;
        end else begin
            clip_c = acc_shr;
        end
        if (acc_shr > Y_HI) begin
            clip_y = Y_HI;
        end else if (acc_shr < Y_LO) begin
            clip_y = Y_LO;
        end else begin
            clip_y = acc_shr;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (sample_fire) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_MUL_B0;
            ST_MUL_B0: state_next = ST_MUL_B1;
            ST_MUL_B1: state_next = ST_MUL_B2;
            ST_MUL_B2: state_next = ST_ACC_B2;
            ST_ACC_B2: state_next = ST_RND_C;
            ST_RND_C:  state_next = ST_CLIP_C;
            ST_CLIP_C: state_next = ST_MUL_A0;
            ST_MUL_A0: state_next = ST_MUL_A1;
            ST_MUL_A1: state_next = ST_MUL_A2;
            ST_MUL_A2: state_next = ST_ACC_A2;
            ST_ACC_A2: state_next = ST_RND_Y;
            ST_RND_Y:  state_next = ST_CLIP_Y;
            ST_CLIP_Y: state_next = (sec_reg == last_sec_reg) ? ST_OUT : ST_FETCH;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            section_count_reg <= 4'd1;
            m_valid_reg       <= 1'b0;
            flag_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                section_count_reg <= cfg_wr_data;
            end
            if (sample_fire) begin
                flag_reg <= 1'b0;
            end else if (((state_reg == ST_MUL_B1) || (state_reg == ST_MUL_B2)
                          || (state_reg == ST_ACC_B2) || (state_reg == ST_RND_C)
                          || (state_reg == ST_MUL_A1) || (state_reg == ST_MUL_A2)
                          || (state_reg == ST_ACC_A2) || (state_reg == ST_RND_Y))
                         && add_ovf) begin
                flag_reg <= 1'b1;
            end else if ((state_reg == ST_CLIP_C) && clip_c_hit) begin
                flag_reg <= 1'b1;
            end else if ((state_reg == ST_CLIP_Y) && clip_y_hit) begin
                flag_reg <= 1'b1;
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            x_reg        <= s_sample;
            sec_reg      <= '0;
            base_reg     <= '0;
            last_sec_reg <= last_sec_next;
        end
        case (state_reg)
            ST_MUL_B0, ST_MUL_B1, ST_MUL_B2, ST_MUL_A0, ST_MUL_A1, ST_MUL_A2:
                prod_reg <= prod_full;
            default: ;
        endcase
        case (state_reg)
            ST_MUL_B0, ST_MUL_A0:
                acc_reg <= '0;
            ST_MUL_B1, ST_MUL_B2, ST_ACC_B2, ST_RND_C,
            ST_MUL_A1, ST_MUL_A2, ST_ACC_A2, ST_RND_Y:
                acc_reg <= add_res;
            default: ;
        endcase
        if (state_reg == ST_CLIP_C) begin
            center_reg <= CENTER_BITS'(clip_c);
        end
        if (state_reg == ST_CLIP_Y) begin
            // The section output feeds the next section.
            x_reg <= SAMPLE_BITS'(clip_y);
            if (sec_reg != last_sec_reg) begin
                sec_reg  <= sec_reg + SEC_AW'(1);
                base_reg <= base_reg + COEF_AW'(COEFS_PER_SECTION);
            end
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_sample_reg <= x_reg;
            m_sat_reg    <= flag_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = m_sample_reg;
    assign m_saturated       = m_sat_reg;

endmodule

`default_nettype wire
